// ===== rtl/sai_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted array package
// Shared codes, widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sai_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int MODE_W      = 2;
    localparam int ITEM_W      = 32;
    localparam int INDEX_W     = 4;
    localparam int READ_W      = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int CAP_W       = 5;
    localparam int STATUS_W    = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_LK_RD,
        S_LK_CAP,
        S_REM_RD,
        S_REM_WR,
        S_DONE
    } state_t;

    // Memory read address source
    typedef enum logic [1:0] {
        RA_PTR_DN,
        RA_PTR_UP,
        RA_INDEX
    } rd_sel_t;

    // Memory write data source
    typedef enum logic {
        WD_SHIFT,
        WD_ITEM
    } wr_sel_t;

    typedef struct packed {
        logic    capture;
        logic    mem_rd;
        rd_sel_t rd_sel;
        logic    mem_wr;
        wr_sel_t wr_sel;
        logic    ptr_dec;
        logic    ptr_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    rd_cap;
        logic    set_full;
        logic    set_bad;
        logic    load_out;
    } sai_cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic bad_index;
        logic ptr_zero;
        logic ptr_up_in_range;
        logic shift_ge;
        logic out_busy;
    } sai_stat_t;

endpackage

// ===== rtl/sai_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted array controller
// Sequences capture, search/shift loops and result hand-off for one operation.
// ----------------------------------------------------------------------------
module sai_ctrl
    import sai_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sai_stat_t stat,
    output sai_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_INSERT: state_next = stat.full      ? S_DONE : S_INS_RD;
                    OP_LOOKUP: state_next = stat.bad_index ? S_DONE : S_LK_RD;
                    OP_REMOVE: state_next = stat.bad_index ? S_DONE : S_REM_RD;
                    OP_NOP:    state_next = S_DONE;
                endcase
            end
            S_INS_RD:  state_next = stat.ptr_zero ? S_INS_PUT : S_INS_CMP;
            S_INS_CMP: state_next = stat.shift_ge ? S_INS_RD : S_INS_PUT;
            S_INS_PUT: state_next = S_DONE;
            S_LK_RD:   state_next = S_LK_CAP;
            S_LK_CAP:  state_next = S_DONE;
            S_REM_RD:  state_next = stat.ptr_up_in_range ? S_REM_WR : S_DONE;
            S_REM_WR:  state_next = S_REM_RD;
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                cmd.set_full = (stat.op == OP_INSERT) && stat.full;
                cmd.set_bad  = ((stat.op == OP_LOOKUP) || (stat.op == OP_REMOVE))
                               && stat.bad_index;
            end
            S_INS_RD:
            begin
                // fetch the entry just below the hole
                cmd.mem_rd = !stat.ptr_zero;
                cmd.rd_sel = RA_PTR_DN;
            end
            S_INS_CMP:
            begin
                // move a not-smaller entry up into the hole
                cmd.mem_wr  = stat.shift_ge;
                cmd.wr_sel  = WD_SHIFT;
                cmd.ptr_dec = stat.shift_ge;
            end
            S_INS_PUT:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = WD_ITEM;
                cmd.cnt_inc = 1'b1;
            end
            S_LK_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = RA_INDEX;
            end
            S_LK_CAP:
            begin
                cmd.rd_cap = 1'b1;
            end
            S_REM_RD:
            begin
                cmd.mem_rd  = stat.ptr_up_in_range;
                cmd.rd_sel  = RA_PTR_UP;
                cmd.cnt_dec = !stat.ptr_up_in_range;
            end
            S_REM_WR:
            begin
                // close the gap by one entry
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = WD_SHIFT;
                cmd.ptr_inc = 1'b1;
            end
            S_DONE:
            begin
                cmd.load_out = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/sai_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted array datapath
// Entry memory, operand and pointer registers, count, capacity and output stage.
// ----------------------------------------------------------------------------
module sai_datapath
    import sai_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CAP_W-1:0]       cfg_wr_data,
    input  logic [MODE_W-1:0]      mode,
    input  logic [ITEM_W-1:0]      item_value,
    input  logic [INDEX_W-1:0]     index,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [READ_W-1:0]      read_value,
    output logic [COUNT_OUT_W-1:0] entry_count,
    output logic [STATUS_W-1:0]    status,
    input  sai_cmd_t               cmd,
    output sai_stat_t              stat
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = CW + 1;
    localparam int LW  = (CW > CAP_W) ? CW : CAP_W;
    localparam int IW  = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int AIW = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int VIW = (VALUE_WIDTH > ITEM_W) ? VALUE_WIDTH : ITEM_W;
    localparam int RW  = (VALUE_WIDTH > READ_W) ? VALUE_WIDTH : READ_W;
    localparam int OW  = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

    logic [VALUE_WIDTH-1:0] entry_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] mem_rd_reg;

    logic [CAP_W-1:0]       cap_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CW-1:0]          ptr_reg;
    logic [CW-1:0]          ptr_next;
    op_t                    op_reg;
    logic [VALUE_WIDTH-1:0] item_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic [VALUE_WIDTH-1:0] rd_reg;
    status_t                st_reg;

    logic                   out_valid_reg;
    logic [READ_W-1:0]      out_read_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    status_t                out_status_reg;

    logic [VIW-1:0]         item_wide;
    logic [IW-1:0]          index_wide;
    logic [AIW-1:0]         idx_addr_wide;
    logic [PW-1:0]          ptr_up;
    logic [CW-1:0]          ptr_dn;
    logic [LW-1:0]          limit;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [RW-1:0]          rd_wide;
    logic [OW-1:0]          count_wide;

    assign item_wide     = VIW'(item_value);
    assign index_wide    = IW'(index);
    assign idx_addr_wide = AIW'(idx_reg);
    assign ptr_up        = PW'(ptr_reg) + PW'(1);
    assign ptr_dn        = ptr_reg - CW'(1);
    assign limit         = (LW'(cap_reg) < LW'(DEPTH)) ? LW'(cap_reg) : LW'(DEPTH);
    assign rd_wide       = RW'(rd_reg);
    assign count_wide    = OW'(count_reg);

    // Status toward the controller
    always_comb
    begin
        stat.op              = op_reg;
        stat.full            = LW'(count_reg) >= limit;
        stat.bad_index       = IW'(idx_reg) >= IW'(count_reg);
        stat.ptr_zero        = (ptr_reg == '0);
        stat.ptr_up_in_range = ptr_up < PW'(count_reg);
        stat.shift_ge        = (mem_rd_reg >= item_reg);
        stat.out_busy        = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RA_PTR_DN: rd_addr = ptr_dn[AW-1:0];
            RA_PTR_UP: rd_addr = ptr_up[AW-1:0];
            RA_INDEX:  rd_addr = idx_addr_wide[AW-1:0];
            default:   rd_addr = '0;
        endcase
    end

    assign wr_addr = ptr_reg[AW-1:0];
    assign wr_data = (cmd.wr_sel == WD_ITEM) ? item_reg : mem_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            mem_rd_reg <= entry_mem[rd_addr];
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.capture)
        begin
            // insert starts its hole at the top, remove at the index
            ptr_next = (op_t'(mode) == OP_INSERT) ? count_reg : index_wide[CW-1:0];
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_dn;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_up[CW-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.capture)
        begin
            op_reg   <= op_t'(mode);
            item_reg <= item_wide[VALUE_WIDTH-1:0];
            idx_reg  <= index;
            rd_reg   <= '0;
            st_reg   <= ST_OK;
        end
        else
        begin
            if (cmd.rd_cap)
            begin
                rd_reg <= mem_rd_reg;
            end
            if (cmd.set_full)
            begin
                st_reg <= ST_FULL;
            end
            else if (cmd.set_bad)
            begin
                st_reg <= ST_BAD_INDEX;
            end
        end
        if (cmd.load_out)
        begin
            out_read_reg   <= rd_wide[READ_W-1:0];
            out_count_reg  <= count_wide[COUNT_OUT_W-1:0];
            out_status_reg <= st_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_read_reg;
    assign entry_count = out_count_reg;
    assign status      = out_status_reg;

endmodule

// ===== rtl/sorted_array_insert_remove.sv =====
// ----------------------------------------------------------------------------
// Sorted array with insert, lookup and remove
// Keeps values in ascending unsigned order in a single-port-style memory.
// ----------------------------------------------------------------------------
// Sequence, accept to out_valid: decode, then lookup reads and captures; insert
//   reads and compares for each entry moved up, then puts the value; remove
//   reads and writes for each entry moved down; full, bad index or no-op skip ahead.
// Throughput: one operation at a time; the next transaction is taken in the
//   cycle after the result is loaded.
// Reset (rst_n, async, active low): table empty, capacity 16, no result held.
// ----------------------------------------------------------------------------
module sorted_array_insert_remove
    import sai_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // capacity register write
    input  logic                   cfg_wr_en,
    input  logic [CAP_W-1:0]       cfg_wr_data,

    // operation channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MODE_W-1:0]      mode,
    input  logic [ITEM_W-1:0]      item_value,
    input  logic [INDEX_W-1:0]     index,

    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [READ_W-1:0]      read_value,
    output logic [COUNT_OUT_W-1:0] entry_count,
    output logic [STATUS_W-1:0]    status
);

    // Controller drives commands, datapath answers with flags:
    //   insert walks down from the top, moving each entry that is not smaller
    //   than the new value up by one, then drops the value into the hole;
    //   remove walks up from the index, pulling each later entry down by one;
    //   lookup is a single registered memory read.
    sai_cmd_t  cmd;
    sai_stat_t stat;

    sai_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath also holds the result register, so a finished transaction
    // waits there while the controller returns to idle and takes the next one.
    sai_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mode        (mode),
        .item_value  (item_value),
        .index       (index),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .read_value  (read_value),
        .entry_count (entry_count),
        .status      (status),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== rtl/sai_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted array port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module sai_checker
    import sai_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [READ_W-1:0]      read_value,
    input logic [COUNT_OUT_W-1:0] entry_count,
    input logic [STATUS_W-1:0]    status
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(read_value) && $stable(entry_count) && $stable(status))
        else $error("result changed while stalled");

    // Drop ready after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");

    // Return zero data on any failed result
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (read_value == '0))
        else $error("nonzero read_value with error status");

    // Raise a new result only out of a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without work");

endmodule

bind sorted_array_insert_remove sai_checker u_sai_checker (.*);

// ===== dv/sorted_array_insert_remove_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted array insert/remove testbench
// Drives insert, lookup, remove and no-op transactions under several capacity
// settings, with random idling on both channels and one long output stall.
// Every result is checked against a shadow table kept by the testbench.
// ----------------------------------------------------------------------------
module sorted_array_insert_remove_tb;
    import sai_pkg::*;

    // One expected result per accepted transaction
    typedef struct {
        logic [READ_W-1:0]      read_value;
        logic [COUNT_OUT_W-1:0] entry_count;
        status_t                status;
    } table_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CAP_W-1:0]       cfg_wr_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [MODE_W-1:0]      mode;
    logic [ITEM_W-1:0]      item_value;
    logic [INDEX_W-1:0]     index;
    logic                   out_valid;
    logic                   out_ready;
    logic [READ_W-1:0]      read_value;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [STATUS_W-1:0]    status;

    // Shadow copy of the table, its fill level and the capacity register
    logic [ITEM_W-1:0] shadow_vals [DEPTH_DEF];
    int                shadow_count;
    int                shadow_cap;

    table_result_t     pending_results [$];

    int err_count       = 0;
    int results_checked = 0;
    int n_ins_ok        = 0;
    int n_ins_full      = 0;
    int n_lookup_ok     = 0;
    int n_remove_ok     = 0;
    int n_bad_index     = 0;
    int n_nop           = 0;

    // Idling control: burst mode shared by the sender and the receiver, long hold for the receiver
    bit burst_mode   = 1'b0;
    int hold_request = 0;
    int hold_left    = 0;

    sorted_array_insert_remove u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .item_value  (item_value),
        .index       (index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .entry_count (entry_count),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow table: apply one accepted transaction, return its expected result
    // ------------------------------------------------------------------------
    function automatic table_result_t table_apply(op_t op, logic [ITEM_W-1:0] val,
                                                  logic [INDEX_W-1:0] idx);
        table_result_t r;
        int limit;
        int pos;
        int k;
        r.read_value = '0;
        r.status     = ST_OK;
        // the limit in force never exceeds the built depth
        limit = (shadow_cap < DEPTH_DEF) ? shadow_cap : DEPTH_DEF;
        case (op)
            OP_INSERT:
            begin
                if (shadow_count >= limit)
                begin
                    r.status = ST_FULL;
                    n_ins_full++;
                end
                else
                begin
                    // land in front of the first entry that is not less,
                    // which puts a new value ahead of its equals
                    pos = 0;
                    while (pos < shadow_count && shadow_vals[pos] < val)
                        pos++;
                    for (k = shadow_count; k > pos; k--)
                        shadow_vals[k] = shadow_vals[k-1];
                    shadow_vals[pos] = val;
                    shadow_count++;
                    n_ins_ok++;
                end
            end
            OP_LOOKUP:
            begin
                if (idx >= shadow_count)
                begin
                    r.status = ST_BAD_INDEX;
                    n_bad_index++;
                end
                else
                begin
                    r.read_value = shadow_vals[idx];
                    n_lookup_ok++;
                end
            end
            OP_REMOVE:
            begin
                if (idx >= shadow_count)
                begin
                    r.status = ST_BAD_INDEX;
                    n_bad_index++;
                end
                else
                begin
                    for (k = idx; k + 1 < shadow_count; k++)
                        shadow_vals[k] = shadow_vals[k+1];
                    shadow_count--;
                    n_remove_ok++;
                end
            end
            default:
                n_nop++;
        endcase
        r.entry_count = shadow_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random field pickers
    // ------------------------------------------------------------------------
    // Favor a narrow range so equal values show up often
    function automatic logic [ITEM_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return ITEM_W'($urandom_range(0, 7));
        else if (roll == 4)
            return '0;
        else if (roll == 5)
            return '1;
        return $urandom;
    endfunction

    // Mostly a live position; sometimes anything, which hits bad index
    function automatic logic [INDEX_W-1:0] pick_index();
        if (shadow_count > 0 && $urandom_range(0, 99) < 85)
            return INDEX_W'($urandom_range(0, shadow_count - 1));
        return INDEX_W'($urandom_range(0, 15));
    endfunction

    // Insert share drops once the table is at its limit so it drains again
    function automatic op_t pick_op(int ins_pct);
        int roll;
        int limit;
        int ins_share;
        roll      = $urandom_range(0, 99);
        limit     = (shadow_cap < DEPTH_DEF) ? shadow_cap : DEPTH_DEF;
        ins_share = (shadow_count >= limit) ? 15 : ins_pct;
        if (roll < 6)
            return OP_NOP;
        if (roll < 6 + ins_share)
            return OP_INSERT;
        if (roll < 6 + ins_share + (94 - ins_share) / 2)
            return OP_LOOKUP;
        return OP_REMOVE;
    endfunction

    // ------------------------------------------------------------------------
    // Drive one transaction; payload changes at the falling edge only.
    // Valid stays high after acceptance until the next call or wait_idle
    // takes the very next falling edge, so no stale transaction is taken.
    // ------------------------------------------------------------------------
    task automatic send_op(op_t op, logic [ITEM_W-1:0] val, logic [INDEX_W-1:0] idx);
        int gap;
        gap = 0;
        if (!burst_mode)
            while ($urandom_range(0, 99) < 25 && gap < 12)
                gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        item_value <= val;
        index      <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(table_apply(op, val, idx));
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write capacity only with the block idle; every transaction yields a
    // result, so an empty queue means nothing is in flight
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_cap = cap;
    endtask

    task automatic run_random(int n_items, int ins_pct);
        int i;
        for (i = 0; i < n_items; i++)
            send_op(pick_op(ins_pct), pick_value(), pick_index());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset capacity; empty-table errors, extremes, duplicates, head/middle/tail
    task automatic test_directed_ops();
        int i;
        send_op(OP_LOOKUP, 32'h0000_0000, 4'd0);
        send_op(OP_REMOVE, 32'h0000_0000, 4'd0);
        send_op(OP_REMOVE, 32'hFFFF_FFFF, 4'd15);
        send_op(OP_NOP,    32'hFFFF_FFFF, 4'd15);
        send_op(OP_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_op(OP_INSERT, 32'h0000_0000, 4'd15);
        send_op(OP_INSERT, 32'h0000_0000, 4'd0);
        send_op(OP_INSERT, 32'h8000_0000, 4'd0);
        send_op(OP_INSERT, 32'h7FFF_FFFF, 4'd0);
        send_op(OP_INSERT, 32'h0000_0001, 4'd0);
        for (i = 0; i < 6; i++)
            send_op(OP_LOOKUP, 32'hFFFF_FFFF, INDEX_W'(i));
        send_op(OP_LOOKUP, 32'h0000_0000, 4'd15);
        send_op(OP_REMOVE, 32'h0000_0000, 4'd0);
        send_op(OP_REMOVE, 32'h0000_0000, 4'd4);
        send_op(OP_REMOVE, 32'h0000_0000, 4'd1);
        for (i = 0; i < 4; i++)
            send_op(OP_LOOKUP, 32'h0000_0000, INDEX_W'(i));
    endtask

    task automatic test_random_full_depth();
        write_capacity(5'd16);
        run_random(80, 55);
        run_random(60, 20);
    endtask

    // Every insert refused; removes and lookups still act on what is stored
    task automatic test_capacity_zero();
        write_capacity(5'd0);
        run_random(30, 30);
    endtask

    task automatic test_capacity_one();
        write_capacity(5'd1);
        run_random(40, 45);
    endtask

    // Register above the built depth: the depth is the limit
    task automatic test_capacity_over_depth();
        write_capacity(5'd31);
        run_random(80, 60);
        write_capacity(5'd7);
        run_random(50, 45);
    endtask

    // Lower the capacity below the fill level: entries stay, inserts refused
    task automatic test_capacity_shrink();
        write_capacity(5'd16);
        while (shadow_count < 12)
            send_op(OP_INSERT, pick_value(), pick_index());
        write_capacity(5'd3);
        run_random(60, 40);
    endtask

    // No idling on either side
    task automatic test_back_to_back();
        write_capacity(5'd16);
        wait_idle();
        burst_mode = 1'b1;
        run_random(80, 50);
        wait_idle();
        burst_mode = 1'b0;
    endtask

    // Hold off the result channel while the sender keeps offering, so the
    // held result stalls the input side
    task automatic test_output_backpressure();
        burst_mode   = 1'b1;
        hold_request = 300;
        run_random(30, 50);
        wait_idle();
        burst_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, stall-free in burst mode, long hold on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (burst_mode)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 25);
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result read_value=%h entry_count=%0d status=%0d",
                         $time, read_value, entry_count, status);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (read_value !== want.read_value)
                begin
                    $display("%0t: read_value mismatch expected %h actual %h",
                             $time, want.read_value, read_value);
                    err_count++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count mismatch expected %0d actual %0d",
                             $time, want.entry_count, entry_count);
                    err_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, status);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        mode         = OP_NOP;
        item_value   = '0;
        index        = '0;
        out_ready    = 1'b0;
        shadow_count = 0;
        shadow_cap   = CAP_RESET;
        foreach (shadow_vals[i])
            shadow_vals[i] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_ops();
        test_random_full_depth();
        test_capacity_zero();
        test_capacity_one();
        test_capacity_over_depth();
        test_capacity_shrink();
        test_back_to_back();
        test_output_backpressure();

        // drain, then allow the longest shift latency for stray results
        wait_idle();
        repeat (40) @(posedge clk);

        $display("Covered %0d inserts (%0d refused as full), %0d lookups, %0d removes,",
                 n_ins_ok + n_ins_full, n_ins_full, n_lookup_ok, n_remove_ok);
        $display("%0d bad-index and %0d no-op transactions; %0d results checked, %0d errors.",
                 n_bad_index, n_nop, results_checked, err_count);
        if (err_count == 0 && pending_results.size() == 0)
            $display("sorted_array_insert_remove regression: pass");
        else
            $display("sorted_array_insert_remove regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("sorted_array_insert_remove regression: fail");
        $finish;
    end

endmodule
